// ===== hdl/opc_pkg.sv =====
`default_nettype none
package opc_pkg;

  // Sizing
  localparam int WINDOW_DEPTH    = 1024;
  localparam int SIGMOID_ENTRIES = 256;
  localparam int HEAD_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int LUT_AW   = $clog2(SIGMOID_ENTRIES + 1);
  localparam int SCALED_W = 29 + $clog2(SIGMOID_ENTRIES) + 1;
  localparam int IDX_W    = SCALED_W - 28;
  localparam int DIVD_W   = FILL_W + 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [16:0]        CONF_ONE = 17'd65536;
  localparam logic signed [31:0] ONE_Q24  = 32'sd16777216;
  localparam logic [10:0] MIN_FILL_RST      = 11'd32;
  localparam logic [10:0] WINDOW_SIZE_RST   = 11'd256;
  localparam logic [23:0] LEARNING_RATE_RST = 24'd167772;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_FILL      = 2'd0,
    CFG_WINDOW_SIZE   = 2'd1,
    CFG_LEARNING_RATE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic        req_type;
    logic [16:0] confidence;
    logic        won;
  } opc_in_t;

  typedef struct packed {
    logic [16:0]        calibrated_confidence;
    logic               calibrated_flag;
    logic [16:0]        win_rate;
    logic [10:0]        window_fill;
    logic [31:0]        outcome_total;
    logic signed [31:0] slope_param;
    logic signed [31:0] offset_param;
  } opc_out_t;

  // Shared multiplier operand select
  typedef enum logic [1:0] {
    MUL_SCORE  = 2'd0,
    MUL_INTERP = 2'd1,
    MUL_GRAD   = 2'd2,
    MUL_DA     = 2'd3
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_SCORE, ST_SCORE, ST_LUT, ST_MUL_INTERP, ST_INTERP,
    ST_MUL_GRAD, ST_GRAD, ST_MUL_DA, ST_UPDATE, ST_FINISH
  } opc_state_e;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     score_en;
    logic     ring_upd;
    logic     lut_en;
    logic     div_start;
    logic     interp_en;
    logic     grad_en;
    logic     update_en;
    logic     load_out;
  } opc_cmd_t;

  typedef struct packed {
    logic is_record;
    logic div_done;
    logic out_free;
  } opc_sts_t;

  typedef logic [63:0] u64_t;
  typedef logic [24:0] sig_lut_t [SIGMOID_ENTRIES+1];

  // Signed shift right, rounding toward zero
  function automatic logic signed [63:0] shr_tz(logic signed [63:0] v, int unsigned s);
    logic signed [63:0] bias;
    bias = (64'sd1 <<< s) - 64'sd1;
    return v[63] ? ((v + bias) >>> s) : (v >>> s);
  endfunction

  // e^(-t) in Q30, t in Q24
  function automatic u64_t exp_neg_q30(u64_t t);
    u64_t u, u2, u3, u4, e;
    u  = t >> 2;
    u2 = (u * u) >> 30;
    u3 = (u2 * u) >> 30;
    u4 = (u3 * u) >> 30;
    e  = (64'd1 << 30) - u + u2 / 64'd2 - u3 / 64'd6 + u4 / 64'd24;
    for (int k = 0; k < 8; k++) e = (e * e + (64'd1 << 29)) >> 30;
    return e;
  endfunction

  // Bitwise long division, elaboration only
  function automatic u64_t long_div(u64_t n, u64_t d);
    u64_t q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_lut_t build_sig_lut();
    sig_lut_t          lut;
    logic signed [63:0] x;
    u64_t              t, e, den, num;
    for (int i = 0; i <= SIGMOID_ENTRIES; i++) begin
      x   = ((64'(i) <<< 28) / SIGMOID_ENTRIES) - (64'sd1 <<< 27);
      t   = x[63] ? u64_t'(-x) : u64_t'(x);
      e   = exp_neg_q30(t);
      den = (64'd1 << 30) + e;
      num = x[63] ? (e << 24) : (64'd1 << 54);
      lut[i] = 25'(long_div(num + den / 64'd2, den));
    end
    return lut;
  endfunction

  localparam sig_lut_t SIG_LUT = build_sig_lut();

endpackage
`default_nettype wire

// ===== hdl/opc_div.sv =====
`default_nettype none
module opc_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [opc_pkg::DIVD_W-1:0] dividend_i,
  input  wire logic [opc_pkg::FILL_W-1:0] divisor_i,
  output logic                            done_o,
  output logic [opc_pkg::DIVD_W-1:0]      quotient_o
);
  import opc_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] quo_q;
  logic [FILL_W-1:0] rem_q, den_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [FILL_W:0]   shifted, sub;
  logic              ge;

  // One quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_q, quo_q[DIVD_W-1]};
    sub     = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DIVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVD_W-2:0], ge};
      rem_q <= ge ? sub[FILL_W-1:0] : shifted[FILL_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== hdl/opc_dp.sv =====
`default_nettype none
module opc_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire opc_pkg::opc_in_t              in_word_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [opc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [opc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire opc_pkg::opc_cmd_t             cmd_i,
  output opc_pkg::opc_sts_t                  sts_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output opc_pkg::opc_out_t                  out_word_o
);
  import opc_pkg::*;

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Configuration and learned state
  logic [10:0]        min_q, window_q;
  logic [23:0]        lr_q;
  logic [HEAD_W-1:0]  head_q;
  logic [FILL_W-1:0]  fill_q, win_q;
  logic signed [31:0] slope_q, offset_q;
  logic [31:0]        total_q;

  // Item registers
  logic [16:0]        c_q;
  logic               rec_q, won_q;
  logic signed [62:0] prod_q;
  logic [28:0]        pos_q;
  logic [24:0]        lo_q, diff_q, sig_q;
  logic [27:0]        frac_q;
  logic signed [25:0] db_q;
  logic signed [33:0] g16_q;

  logic               ring_mem [WINDOW_DEPTH];
  logic               ring_old_q;

  opc_out_t           out_q;
  logic               out_valid_q;

  logic               cfg_hit;
  assign cfg_hit = cfg_we_i && (cfg_idx_i == CFG_MIN_FILL ||
                                cfg_idx_i == CFG_WINDOW_SIZE ||
                                cfg_idx_i == CFG_LEARNING_RATE);

  // Window bookkeeping
  logic [31:0]       w_eff;
  logic              full;
  logic [FILL_W:0]   slot_sum, slot_wrap;
  logic [HEAD_W-1:0] slot_idx, head_inc;
  logic [FILL_W-1:0] fill_d, win_d;
  logic [HEAD_W-1:0] head_d;

  always_comb begin
    if (window_q == 11'd0) w_eff = 32'd1;
    else if (32'(window_q) > 32'(WINDOW_DEPTH)) w_eff = 32'(WINDOW_DEPTH);
    else w_eff = 32'(window_q);
    full      = 32'(fill_q) >= w_eff;
    slot_sum  = (FILL_W+1)'(head_q) + (FILL_W+1)'(fill_q);
    slot_wrap = (slot_sum >= (FILL_W+1)'(WINDOW_DEPTH)) ?
                slot_sum - (FILL_W+1)'(WINDOW_DEPTH) : slot_sum;
    slot_idx  = slot_wrap[HEAD_W-1:0];
    head_inc  = (head_q == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + HEAD_W'(1);
    head_d    = full ? head_inc : head_q;
    fill_d    = full ? fill_q : fill_q + FILL_W'(1);
    win_d     = win_q - FILL_W'(full && ring_old_q) + FILL_W'(won_q);
  end

  // Shared multiplier
  logic signed [33:0] ma;
  logic signed [28:0] mb;
  logic signed [62:0] prod_d;
  logic signed [25:0] err;

  always_comb begin
    err = $signed({1'b0, sig_q}) - (won_q ? 26'sd16777216 : 26'sd0);
    case (cmd_i.mul_sel)
      MUL_SCORE: begin
        ma = 34'(slope_q);
        mb = $signed({12'd0, c_q});
      end
      MUL_INTERP: begin
        ma = $signed({9'd0, diff_q});
        mb = $signed({1'b0, frac_q});
      end
      MUL_GRAD: begin
        ma = $signed({10'd0, lr_q});
        mb = 29'(err);
      end
      MUL_DA: begin
        ma = g16_q;
        mb = $signed({12'd0, c_q});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod_d = 63'(ma) * 63'(mb);
  end

  // Score, clamp to the table span
  logic signed [63:0] score, score_cl;
  always_comb begin
    score = shr_tz(64'(prod_q), 16) + 64'(offset_q);
    if (score < -(64'sd1 <<< 27)) score_cl = -(64'sd1 <<< 27);
    else if (score > (64'sd1 <<< 27)) score_cl = 64'sd1 <<< 27;
    else score_cl = score;
  end

  // Table lookup
  logic [SCALED_W-1:0] scaled;
  logic [IDX_W-1:0]    idx;
  logic [LUT_AW-1:0]   idx_lo;
  logic [24:0]         lo_d, hi_d, diff_d;
  logic [27:0]         frac_d;

  always_comb begin
    scaled = SCALED_W'(pos_q) * SCALED_W'(SIGMOID_ENTRIES);
    idx    = scaled[SCALED_W-1:28];
    idx_lo = idx[LUT_AW-1:0];
    hi_d   = '0;
    if (idx >= IDX_W'(SIGMOID_ENTRIES)) begin
      lo_d   = SIG_LUT[SIGMOID_ENTRIES];
      diff_d = '0;
      frac_d = '0;
    end else begin
      lo_d = SIG_LUT[idx_lo];
      hi_d = SIG_LUT[idx_lo + LUT_AW'(1)];
      if (hi_d < lo_d) begin
        diff_d = '0;
        frac_d = '0;
      end else begin
        diff_d = hi_d - lo_d;
        frac_d = scaled[27:0];
      end
    end
  end

  // Parameter step
  logic signed [63:0] da;
  always_comb da = shr_tz(64'(prod_q), 24);

  // Win rate divider
  logic [DIVD_W-1:0] quot;
  logic              div_done;
  opc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (DIVD_W'({win_q, 16'd0}) + DIVD_W'(fill_q >> 1)),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Result word
  logic [17:0] ans_rnd;
  logic [16:0] answer;
  always_comb begin
    ans_rnd = 18'((26'(sig_q) + 26'd128) >> 8);
    if (rec_q) answer = '0;
    else if (11'(fill_q) < min_q) answer = c_q;
    else if (ans_rnd > 18'(CONF_ONE)) answer = CONF_ONE;
    else answer = ans_rnd[16:0];
  end

  // Configuration and learned state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= MIN_FILL_RST;
      window_q <= WINDOW_SIZE_RST;
      lr_q     <= LEARNING_RATE_RST;
      head_q   <= '0;
      fill_q   <= '0;
      win_q    <= '0;
      slope_q  <= ONE_Q24;
      offset_q <= '0;
      total_q  <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_idx_i)
        CFG_MIN_FILL:      min_q    <= cfg_data_i[10:0];
        CFG_WINDOW_SIZE:   window_q <= cfg_data_i[10:0];
        CFG_LEARNING_RATE: lr_q     <= cfg_data_i[23:0];
        default: ;
      endcase
      head_q   <= '0;
      fill_q   <= '0;
      win_q    <= '0;
      slope_q  <= ONE_Q24;
      offset_q <= '0;
      total_q  <= '0;
    end else begin
      if (cmd_i.ring_upd) begin
        head_q <= head_d;
        fill_q <= fill_d;
        win_q  <= win_d;
      end
      if (cmd_i.update_en) begin
        slope_q  <= sat32(64'(slope_q) - da);
        offset_q <= sat32(64'(offset_q) - 64'(db_q));
        if (total_q != 32'hffff_ffff) total_q <= total_q + 32'd1;
      end
    end
  end

  // Outcome ring: oldest entry read every cycle, new outcome written at the tail
  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_upd) ring_mem[slot_idx] <= won_q;
    ring_old_q <= ring_mem[head_q];
  end

  // Per-item datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      c_q   <= (in_word_i.confidence > CONF_ONE) ? CONF_ONE : in_word_i.confidence;
      rec_q <= !in_word_i.req_type;
      won_q <= in_word_i.won;
    end
    if (cmd_i.mul_en) prod_q <= prod_d;
    if (cmd_i.score_en) pos_q <= 29'(score_cl + (64'sd1 <<< 27));
    if (cmd_i.lut_en) begin
      lo_q   <= lo_d;
      diff_q <= diff_d;
      frac_q <= frac_d;
    end
    if (cmd_i.interp_en) sig_q <= lo_q + prod_q[52:28];
    if (cmd_i.grad_en) begin
      db_q  <= 26'(shr_tz(64'(prod_q), 24));
      g16_q <= 34'(shr_tz(64'(prod_q), 16));
    end
    if (cmd_i.load_out) begin
      out_q.calibrated_confidence <= answer;
      out_q.calibrated_flag       <= 11'(fill_q) >= min_q;
      out_q.win_rate              <= (fill_q == '0) ? 17'd0 : quot[16:0];
      out_q.window_fill           <= 11'(fill_q);
      out_q.outcome_total         <= total_q;
      out_q.slope_param           <= slope_q;
      out_q.offset_param          <= offset_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.load_out) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  assign sts_o.is_record = rec_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_word_o      = out_q;

  a_win_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_q <= fill_q) else $error("win count exceeds window fill");
  a_fill_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(WINDOW_DEPTH)) else $error("window fill beyond ring depth");
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (div_done && (!out_valid_q || !out_stall_i)))
    else $error("result loaded before win rate done or over a waiting word");
  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ring_upd && !cfg_hit && !full) |=> fill_q == $past(fill_q) + FILL_W'(1))
    else $error("record did not grow a non-full window");

endmodule
`default_nettype wire

// ===== hdl/opc_ctrl.sv =====
`default_nettype none
module opc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire opc_pkg::opc_sts_t sts_i,
  output opc_pkg::opc_cmd_t      cmd_o
);
  import opc_pkg::*;

  opc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Sequencer: score, lookup, interpolate, then gradient and update for records, then load the result
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_SCORE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_MUL_SCORE;
        end
      end
      ST_MUL_SCORE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SCORE;
        state_d = ST_SCORE;
      end
      ST_SCORE: begin
        cmd_o.score_en = 1'b1;
        cmd_o.ring_upd = sts_i.is_record;
        state_d = ST_LUT;
      end
      ST_LUT: begin
        cmd_o.lut_en    = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d = ST_MUL_INTERP;
      end
      ST_MUL_INTERP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_INTERP;
        state_d = ST_INTERP;
      end
      ST_INTERP: begin
        cmd_o.interp_en = 1'b1;
        state_d = sts_i.is_record ? ST_MUL_GRAD : ST_FINISH;
      end
      ST_MUL_GRAD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GRAD;
        state_d = ST_GRAD;
      end
      ST_GRAD: begin
        cmd_o.grad_en = 1'b1;
        state_d = ST_MUL_DA;
      end
      ST_MUL_DA: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DA;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update_en = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.div_done && sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// ===== hdl/online_platt_calibrator.sv =====
// Online Platt calibrator.
// Input channel (in_valid_i / in_stall_o / in_word_i): a word is taken when
// valid is high and stall is low. A record word pushes the won bit into the
// sliding window and takes one gradient step on slope and offset; a query word
// returns the calibrated confidence (raw confidence until the window holds
// the configured minimum fill). Every word yields exactly one result word on
// the output channel (out_valid_o / out_stall_i / out_word_o).
// One word is in work at a time; the next word is not taken until the
// current one finishes. The pace is set by the bit-serial win-rate divider
// (one quotient bit per cycle, 28 bits), which runs beside the shared
// multiplier steps of the interpolation and gradient.
// A finished result sits in an output register; the next word is taken while
// it waits. If the receiver stalls, the next result holds in the sequencer
// until the output register frees.
// Reset (rst_ni, asynchronous, low) loads the default configuration, slope 1.0
// and clears window, counts and offset. A config write (cfg_we_i, cfg_idx_i,
// cfg_data_i) clears the same state; users write only while idle (unchecked).
`default_nettype none
module online_platt_calibrator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire opc_pkg::opc_in_t               in_word_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output opc_pkg::opc_out_t                   out_word_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [opc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [opc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import opc_pkg::*;

  opc_cmd_t cmd;
  opc_sts_t sts;

  opc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  opc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire
